[hdl/mbag_pkg.sv]
// Shared types, constants and the control program of the multiset bag engine.
package mbag_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam logic [1:0] ACT_INSERT    = 2'd0;
   localparam logic [1:0] ACT_ERASE_ALL = 2'd1;
   localparam logic [1:0] ACT_ERASE_ONE = 2'd2;
   localparam logic [1:0] ACT_COUNT     = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]             action;
      logic [VALUE_WIDTH-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] amount;
      logic [CNT_W-1:0] entries_held;
   } rsp_type;

   // Step addresses of the control program.
   typedef enum logic [3:0] {
      STEP_IDLE     = 4'd0,
      STEP_DISPATCH = 4'd1,
      STEP_INS      = 4'd2,
      STEP_INS_REJ  = 4'd3,
      STEP_SCAN     = 4'd4,
      STEP_CHECK    = 4'd5,
      STEP_HIT      = 4'd6,
      STEP_CNT_ADV  = 4'd7,
      STEP_MOVE_RD  = 4'd8,
      STEP_MOVE_WR  = 4'd9,
      STEP_DONE     = 4'd10,
      STEP_MISS     = 4'd11,
      STEP_REPLY    = 4'd12
   } step_type;

   // Branch conditions tested by a control word.
   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_INSERT,
      COND_FULL,
      COND_STAY,
      COND_END,
      COND_NOT_COUNT,
      COND_IS_ALL,
      COND_FOUND_OR_NOT_ONE,
      COND_RSP_BUSY
   } cond_type;

   typedef struct packed {
      logic take;      // open the request channel
      logic start;     // clear index, amount and status
      logic adv;       // step the index while the scan stays in its loop
      logic idx_inc;
      logic amt_inc;
      logic amt_one;
      logic fill_inc;
      logic fill_dec;
      logic wr_val;    // write the request value at the fill slot
      logic wr_move;   // write the read data at the index slot
      logic rd_last;   // read the last held entry instead of the next index
      logic rd_hold;   // keep the read data register
      logic st_full;
      logic st_miss;
      logic rsp_load;
   } ops_type;

   typedef struct packed {
      ops_type  ops;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } uword_type;

   function automatic uword_type ucode_rom(input step_type pc);
      uword_type w;
      w = '{ops: '0, cond: COND_ALWAYS, tgt_true: STEP_IDLE, tgt_false: STEP_IDLE};
      case (pc)
         STEP_IDLE: begin
            w.ops.take  = 1'b1;
            w.ops.start = 1'b1;
            w.cond      = COND_NO_REQ;
            w.tgt_true  = STEP_IDLE;
            w.tgt_false = STEP_DISPATCH;
         end
         STEP_DISPATCH: begin
            w.cond      = COND_IS_INSERT;
            w.tgt_true  = STEP_INS;
            w.tgt_false = STEP_SCAN;
         end
         STEP_INS: begin
            w.cond      = COND_FULL;
            w.tgt_true  = STEP_INS_REJ;
            w.tgt_false = STEP_REPLY;
            w.ops.wr_val   = 1'b1;
            w.ops.fill_inc = 1'b1;
            w.ops.amt_one  = 1'b1;
         end
         STEP_INS_REJ: begin
            w.ops.st_full = 1'b1;
            w.tgt_true    = STEP_REPLY;
         end
         STEP_SCAN: begin
            w.ops.adv   = 1'b1;
            w.cond      = COND_STAY;
            w.tgt_true  = STEP_SCAN;
            w.tgt_false = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.cond      = COND_END;
            w.tgt_true  = STEP_DONE;
            w.tgt_false = STEP_HIT;
         end
         STEP_HIT: begin
            w.ops.amt_inc = 1'b1;
            w.cond        = COND_NOT_COUNT;
            w.tgt_true    = STEP_MOVE_RD;
            w.tgt_false   = STEP_CNT_ADV;
         end
         STEP_CNT_ADV: begin
            w.ops.idx_inc = 1'b1;
            w.tgt_true    = STEP_SCAN;
         end
         STEP_MOVE_RD: begin
            w.ops.rd_last  = 1'b1;
            w.ops.fill_dec = 1'b1;
            w.tgt_true     = STEP_MOVE_WR;
         end
         STEP_MOVE_WR: begin
            w.ops.wr_move = 1'b1;
            w.ops.rd_hold = 1'b1;
            w.cond        = COND_IS_ALL;
            w.tgt_true    = STEP_SCAN;
            w.tgt_false   = STEP_DONE;
         end
         STEP_DONE: begin
            w.cond      = COND_FOUND_OR_NOT_ONE;
            w.tgt_true  = STEP_REPLY;
            w.tgt_false = STEP_MISS;
         end
         STEP_MISS: begin
            w.ops.st_miss = 1'b1;
            w.tgt_true    = STEP_REPLY;
         end
         STEP_REPLY: begin
            w.ops.rsp_load = 1'b1;
            w.cond         = COND_RSP_BUSY;
            w.tgt_true     = STEP_REPLY;
            w.tgt_false    = STEP_IDLE;
         end
         default: begin
            w.tgt_true = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[hdl/multiset_bag_engine_top.sv]
// Top level of the multiset bag engine: sequencer, entry store and response register.
//
// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_stall   req_data  (action, item_value)
// response  out        rsp_valid / rsp_stall   rsp_data  (status, amount, entries_held)
//
// An insert passes from acceptance through the dispatch and insert steps to the reply step,
// with a reject step between when the store is full and the insert is rejected. Erase and
// count walk the held entries through the single read port of the entry store, one entry
// per cycle while no match is found; each match passes through a hit step, and an erase
// also through the move steps, which read the last entry and write it into the freed slot.
// An erase-one that matches at slot j ends there; one that finds nothing adds a miss step.
// Reset clears the entry count and the control state; the store itself needs no clearing.
// A finished response waits in its register under rsp_stall while the next request is
// already accepted; the sequencer only waits in its reply step while that register stalls.
module multiset_bag_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mbag_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mbag_pkg::rsp_type rsp_data
);

   localparam int AW = mbag_pkg::ADDR_W;
   localparam int CW = mbag_pkg::CNT_W;
   localparam int VW = mbag_pkg::VALUE_WIDTH;

   // Step counter and the control word it selects.
   mbag_pkg::step_type  pc_ff, pc_in;
   mbag_pkg::uword_type uw;

   // Datapath registers.
   logic [1:0]  action_ff, action_in;
   logic [VW-1:0] value_ff, value_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] amount_ff, amount_in;
   logic [1:0]  status_ff, status_in;
   logic [VW-1:0] rd_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   mbag_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Entry store: one write and one registered read per cycle.
   logic [VW-1:0] store_mem [mbag_pkg::CAPACITY];

   logic          req_fire;
   logic          scan_end;
   logic          scan_miss;
   logic          stay;
   logic          full;
   logic          rsp_busy;
   logic          cond_hit;
   logic [CW-1:0] fill_m1;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;

   assign uw = mbag_pkg::ucode_rom(pc_ff);

   assign req_stall = ~uw.ops.take;
   assign req_fire  = req_valid & uw.ops.take;

   // The scan compares the entry at the current index, taken from the registered read data.
   assign scan_end  = (idx_ff >= fill_ff);
   assign scan_miss = (rd_data_ff != value_ff);
   assign stay      = ~scan_end & scan_miss;
   assign full      = (fill_ff == CW'(mbag_pkg::CAPACITY));
   assign rsp_busy  = rsp_valid_ff & rsp_stall;
   assign fill_m1   = fill_ff - CW'(1);

   always_comb begin
      case (uw.cond)
         mbag_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         mbag_pkg::COND_NO_REQ:    cond_hit = ~req_valid;
         mbag_pkg::COND_IS_INSERT: cond_hit = (action_ff == mbag_pkg::ACT_INSERT);
         mbag_pkg::COND_FULL:      cond_hit = full;
         mbag_pkg::COND_STAY:      cond_hit = stay;
         mbag_pkg::COND_END:       cond_hit = scan_end;
         mbag_pkg::COND_NOT_COUNT: cond_hit = (action_ff != mbag_pkg::ACT_COUNT);
         mbag_pkg::COND_IS_ALL:    cond_hit = (action_ff == mbag_pkg::ACT_ERASE_ALL);
         mbag_pkg::COND_FOUND_OR_NOT_ONE: begin
            cond_hit = (action_ff != mbag_pkg::ACT_ERASE_ONE) || (amount_ff != '0);
         end
         mbag_pkg::COND_RSP_BUSY:  cond_hit = rsp_busy;
         default:                  cond_hit = 1'b1;
      endcase
      pc_in = cond_hit ? uw.tgt_true : uw.tgt_false;
   end

   always_comb begin
      action_in = req_fire ? req_data.action : action_ff;
      value_in  = req_fire ? req_data.item_value : value_ff;

      idx_in = idx_ff;
      if (uw.ops.start) begin
         idx_in = '0;
      end else if (uw.ops.idx_inc || (uw.ops.adv && stay)) begin
         idx_in = idx_ff + CW'(1);
      end

      fill_in = fill_ff;
      if (uw.ops.fill_inc && !full) begin
         fill_in = fill_ff + CW'(1);
      end else if (uw.ops.fill_dec) begin
         fill_in = fill_m1;
      end

      amount_in = amount_ff;
      if (uw.ops.start) begin
         amount_in = '0;
      end else if (uw.ops.amt_one && !full) begin
         amount_in = CW'(1);
      end else if (uw.ops.amt_inc) begin
         amount_in = amount_ff + CW'(1);
      end

      status_in = status_ff;
      if (uw.ops.start) begin
         status_in = mbag_pkg::STATUS_DONE;
      end else if (uw.ops.st_full) begin
         status_in = mbag_pkg::STATUS_FULL;
      end else if (uw.ops.st_miss) begin
         status_in = mbag_pkg::STATUS_NOT_FOUND;
      end
   end

   // The read address follows the next index, so a new entry is ready every cycle outside a move.
   assign rd_addr = uw.ops.rd_last ? fill_m1[AW-1:0] : idx_in[AW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data_ff;
      if (uw.ops.wr_val && !full) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[AW-1:0];
         wr_data = value_ff;
      end else if (uw.ops.wr_move) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (!uw.ops.rd_hold) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // The response register frees as soon as the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_busy;
      rsp_data_in  = rsp_data_ff;
      if (uw.ops.rsp_load && !rsp_busy) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = status_ff;
         rsp_data_in.amount       = amount_ff;
         rsp_data_in.entries_held = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= mbag_pkg::STEP_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      amount_ff   <= amount_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/mbag_checker.sv]
// Port-level checks of the multiset bag engine and their binding to the top level.
module mbag_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mbag_pkg::rsp_type rsp_data
);

   // No response is shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A response never claims more entries than the store holds.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entries_held <= 7'(mbag_pkg::CAPACITY)))
      else $error("entries held beyond capacity");

   // A rejected insert only happens with a full store and moves nothing.
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mbag_pkg::STATUS_FULL) |->
      (rsp_data.amount == '0 && rsp_data.entries_held == 7'(mbag_pkg::CAPACITY)))
      else $error("full status with inconsistent fields");

   // A miss removes nothing.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mbag_pkg::STATUS_NOT_FOUND) |->
      (rsp_data.amount == '0))
      else $error("not-found status with nonzero amount");

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind multiset_bag_engine_top mbag_checker u_mbag_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[sim/tb_multiset_bag_engine_top.sv]
// Self-checking testbench for the multiset bag engine: random and directed bag requests.
module tb_multiset_bag_engine_top;

   localparam int          CAPACITY     = mbag_pkg::CAPACITY;
   localparam int          VALUE_WIDTH  = mbag_pkg::VALUE_WIDTH;
   localparam int          CNT_W        = mbag_pkg::CNT_W;
   localparam int          RANDOM_ITEMS = 1100;
   localparam int          IDLE_PCT     = 31;
   localparam int          POOL_SIZE    = 8;
   // Erase-all of a completely full bag of one value is the slowest request.
   localparam int          DRAIN_CYCLES = 8 * CAPACITY + 64;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int          QUIET_FROM   = 450;
   localparam int          QUIET_TO     = 650;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mbag_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mbag_pkg::rsp_type rsp_data;

   // Requests waiting for the driver, and replies the bag shadow says must come back.
   mbag_pkg::req_type requests_pending [$];
   mbag_pkg::rsp_type replies_due [$];
   int               total_requests = 0;
   int               requests_sent  = 0;
   int               replies_seen   = 0;
   int               mismatches     = 0;
   int unsigned      cycle_cnt      = 0;

   // Shadow of the bag: the held values sit in slots below shadow_fill.
   logic [VALUE_WIDTH-1:0] shadow_slots [CAPACITY];
   int unsigned            shadow_fill = 0;
   logic [VALUE_WIDTH-1:0] value_pool [POOL_SIZE];

   multiset_bag_engine_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // Applies one request to the shadow bag and returns the reply it must produce.
   // A removed entry is replaced by the last held one, and an erase-all looks at the
   // same slot again after such a move.
   function automatic mbag_pkg::rsp_type apply_bag_request(input mbag_pkg::req_type r);
      logic [VALUE_WIDTH-1:0] v;
      int unsigned            slot;
      logic                   removed;
      mbag_pkg::rsp_type      o;
      v        = r.item_value;
      o.status = mbag_pkg::STATUS_DONE;
      o.amount = '0;
      case (r.action)
         mbag_pkg::ACT_INSERT: begin
            if (shadow_fill >= CAPACITY) begin
               o.status = mbag_pkg::STATUS_FULL;
            end else begin
               shadow_slots[shadow_fill] = v;
               shadow_fill++;
               o.amount = CNT_W'(1);
            end
         end
         mbag_pkg::ACT_ERASE_ALL: begin
            slot = 0;
            while (slot < shadow_fill) begin
               if (shadow_slots[slot] == v) begin
                  shadow_fill--;
                  shadow_slots[slot] = shadow_slots[shadow_fill];
                  o.amount = o.amount + CNT_W'(1);
               end else begin
                  slot++;
               end
            end
         end
         mbag_pkg::ACT_ERASE_ONE: begin
            slot    = 0;
            removed = 1'b0;
            while (!removed && slot < shadow_fill) begin
               if (shadow_slots[slot] == v) begin
                  shadow_fill--;
                  shadow_slots[slot] = shadow_slots[shadow_fill];
                  removed = 1'b1;
               end else begin
                  slot++;
               end
            end
            if (removed) begin
               o.amount = CNT_W'(1);
            end else begin
               o.status = mbag_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
            for (slot = 0; slot < shadow_fill; slot++) begin
               if (shadow_slots[slot] == v) begin
                  o.amount = o.amount + CNT_W'(1);
               end
            end
         end
      endcase
      o.entries_held = CNT_W'(shadow_fill);
      return o;
   endfunction

   function automatic void queue_request(input logic [1:0] act,
                                         input logic [VALUE_WIDTH-1:0] v);
      mbag_pkg::req_type r;
      r.action     = act;
      r.item_value = v;
      requests_pending.push_back(r);
   endfunction

   // Mostly values from a small pool so that copies pile up; now and then a fresh one.
   function automatic logic [VALUE_WIDTH-1:0] pick_value(input int pool_used);
      if ($urandom_range(99) < 85) begin
         return value_pool[$urandom_range(pool_used - 1)];
      end
      return $urandom;
   endfunction

   // Request driver. The payload only moves once the current request is taken or
   // the channel is empty; valid is never derived from the stall.
   always @(posedge clock) begin : drive_requests
      logic taken;
      logic idle;
      taken = req_valid && !req_stall;
      idle  = ($urandom_range(99) < IDLE_PCT) &&
              !(requests_sent >= QUIET_FROM && requests_sent < QUIET_TO);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken) begin
            void'(requests_pending.pop_front());
            requests_sent <= requests_sent + 1;
         end
         if (!req_valid || taken) begin
            if (requests_pending.size() > 0 && !idle) begin
               req_valid <= 1'b1;
               req_data  <= requests_pending[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor. It checks a reply before it records the request taken at the
   // same edge, so the order of the two queue operations never matters.
   always @(posedge clock) begin : watch_replies
      mbag_pkg::rsp_type want;
      logic              stall_now;
      stall_now = ($urandom_range(99) < IDLE_PCT) &&
                  !(replies_seen >= QUIET_FROM && replies_seen < QUIET_TO);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen <= replies_seen + 1;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected reply: status %0d amount %0d held %0d",
                           rsp_data.status, rsp_data.amount, rsp_data.entries_held);
               end
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.status !== want.status || rsp_data.amount !== want.amount ||
                   rsp_data.entries_held !== want.entries_held) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Reply %0d mismatch: expected status %0d amount %0d held %0d, %s",
                              replies_seen, want.status, want.amount, want.entries_held,
                              $sformatf("got status %0d amount %0d held %0d",
                                        rsp_data.status, rsp_data.amount,
                                        rsp_data.entries_held));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            replies_due.push_back(apply_bag_request(req_data));
         end
         rsp_stall <= stall_now;
      end
   end

   initial begin : watchdog
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int          len;
      int          n;
      int          pool_used;
      int          roll;
      mix_type     mix;
      logic [1:0]  act;

      for (int i = 0; i < POOL_SIZE; i++) begin
         value_pool[i] = $urandom;
      end

      // Directed: the empty bag, both value extremes, duplicates, a miss on a
      // non-empty bag, and the erase-one that moves the last entry forward.
      queue_request(mbag_pkg::ACT_COUNT,     '0);
      queue_request(mbag_pkg::ACT_ERASE_ALL, 32'd5);
      queue_request(mbag_pkg::ACT_ERASE_ONE, 32'd5);
      queue_request(mbag_pkg::ACT_INSERT,    '0);
      queue_request(mbag_pkg::ACT_INSERT,    '1);
      queue_request(mbag_pkg::ACT_INSERT,    '0);
      queue_request(mbag_pkg::ACT_INSERT,    32'hA5A5_5A5A);
      queue_request(mbag_pkg::ACT_INSERT,    '0);
      queue_request(mbag_pkg::ACT_COUNT,     '0);
      queue_request(mbag_pkg::ACT_COUNT,     '1);
      queue_request(mbag_pkg::ACT_ERASE_ONE, '0);
      queue_request(mbag_pkg::ACT_COUNT,     '0);
      queue_request(mbag_pkg::ACT_ERASE_ONE, 32'h0000_1234);
      queue_request(mbag_pkg::ACT_ERASE_ALL, 32'h0000_1234);
      queue_request(mbag_pkg::ACT_COUNT,     32'h5A5A_A5A5);
      queue_request(mbag_pkg::ACT_ERASE_ALL, '0);
      queue_request(mbag_pkg::ACT_COUNT,     '0);
      queue_request(mbag_pkg::ACT_ERASE_ALL, '1);
      queue_request(mbag_pkg::ACT_ERASE_ONE, 32'hA5A5_5A5A);
      queue_request(mbag_pkg::ACT_ERASE_ALL, 32'hA5A5_5A5A);
      queue_request(mbag_pkg::ACT_COUNT,     '1);

      total_requests = requests_pending.size() + RANDOM_ITEMS;

      // Random part in runs: fill runs push the bag to full and beyond, drain runs
      // empty it again, even runs mix all actions. A pool of one value builds up
      // the largest counts and erase-all sizes.
      mix       = MIX_FILL;
      len       = CAPACITY + 8;
      pool_used = 1;
      while (requests_pending.size() < total_requests) begin
         for (n = 0; n < len; n++) begin
            roll = $urandom_range(99);
            case (mix)
               MIX_FILL: begin
                  act = (roll < 88) ? mbag_pkg::ACT_INSERT :
                        (roll < 93) ? mbag_pkg::ACT_COUNT :
                        (roll < 97) ? mbag_pkg::ACT_ERASE_ONE : mbag_pkg::ACT_ERASE_ALL;
               end
               MIX_DRAIN: begin
                  act = (roll < 20) ? mbag_pkg::ACT_INSERT :
                        (roll < 55) ? mbag_pkg::ACT_ERASE_ONE :
                        (roll < 80) ? mbag_pkg::ACT_ERASE_ALL : mbag_pkg::ACT_COUNT;
               end
               default: begin
                  act = (roll < 25) ? mbag_pkg::ACT_INSERT :
                        (roll < 50) ? mbag_pkg::ACT_ERASE_ONE :
                        (roll < 75) ? mbag_pkg::ACT_ERASE_ALL : mbag_pkg::ACT_COUNT;
               end
            endcase
            queue_request(act, pick_value(pool_used));
         end
         value_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
         mix       = mix_type'($urandom_range(2));
         len       = $urandom_range(20, 90);
         pool_used = $urandom_range(1, POOL_SIZE);
      end
      total_requests = requests_pending.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (!(requests_sent == total_requests && replies_due.size() == 0)) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
